FILE: hw/rtl/ackp_pkg.sv
// Package for the acknowledgement record list parser.
// Holds the transaction structs, status codes, sequencer states and fixed constants.
// No dependencies.
package ackp_pkg;

    localparam int unsigned LEN_BYTES  = 2;
    localparam int unsigned REC_BYTES  = 16;
    localparam int unsigned HALF_BYTES = 8;
    localparam int unsigned CNT_W      = 17;
    localparam int unsigned IDX_W      = 6;
    localparam logic [CNT_W-1:0] BYTES_SAT = 17'h1FFFF;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_TRUNC  = 2'd1;
    localparam logic [1:0] ST_BADLEN = 2'd2;
    localparam logic [1:0] ST_UNSUP  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [63:0] epoch_value;
        logic [63:0] sequence_value;
        logic        is_record;
        logic [1:0]  parse_status;
        logic        run_end;
    } result_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [127:0]     data;
    } store_wr_t;

    typedef struct packed {
        logic             valid;
        logic [1:0]       status;
        logic             has_records;
        logic [IDX_W-1:0] last_idx;
    } msg_done_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_STATUS
    } emit_state_t;

endpackage

FILE: hw/rtl/ackp_store.sv
// Record store: one write port and one registered read port.
// Depends on ackp_pkg.
module ackp_store
    import ackp_pkg::*;
#(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = 5
)
(
    input  logic              clk,
    input  store_wr_t         wr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [127:0]      rd_data
);

    logic [127:0] mem [DEPTH];
    logic [127:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[ADDR_W-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/ackp_parse.sv
// Byte parser: length field, record assembly, store writes and final checks.
// Depends on ackp_pkg.
module ackp_parse
    import ackp_pkg::*;
#(
    parameter int unsigned MAX_RECORDS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_item_t  item,
    output store_wr_t wr,
    output msg_done_t done
);

    logic [CNT_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic [15:0]      declared_reg, declared_next;
    logic [55:0]      acc_reg, acc_next;
    logic [63:0]      epoch_reg, epoch_next;
    logic [IDX_W-1:0] stored_reg, stored_next;

    logic [63:0]      word;
    logic [3:0]       phase;
    logic [CNT_W-1:0] total;
    logic [11:0]      count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            declared_reg   <= '0;
            acc_reg        <= '0;
            epoch_reg      <= '0;
            stored_reg     <= '0;
        end
        else
        begin
            bytes_seen_reg <= bytes_seen_next;
            declared_reg   <= declared_next;
            acc_reg        <= acc_next;
            epoch_reg      <= epoch_next;
            stored_reg     <= stored_next;
        end
    end

    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        declared_next   = declared_reg;
        acc_next        = acc_reg;
        epoch_next      = epoch_reg;
        stored_next     = stored_reg;
        word            = {acc_reg, item.data_byte};
        phase           = bytes_seen_reg[3:0] - 4'(LEN_BYTES);
        total           = (bytes_seen_reg == BYTES_SAT) ? bytes_seen_reg
                                                        : bytes_seen_reg + 1'b1;
        count           = '0;
        wr              = '0;
        done            = '0;

        if (accept)
        begin
            if (bytes_seen_reg < CNT_W'(LEN_BYTES))
            begin
                declared_next = {declared_reg[7:0], item.data_byte};
            end
            else
            begin
                acc_next = word[55:0];
                if (phase == 4'(HALF_BYTES - 1))
                begin
                    epoch_next = word;
                end
                else if (phase == 4'(REC_BYTES - 1) && stored_reg < IDX_W'(MAX_RECORDS))
                begin
                    wr.en       = 1'b1;
                    wr.addr     = stored_reg;
                    wr.data     = {epoch_reg, word};
                    stored_next = stored_reg + 1'b1;
                end
            end
            bytes_seen_next = total;

            if (item.final_byte)
            begin
                count = declared_next[15:4];
                done.valid = 1'b1;
                if (total < CNT_W'(LEN_BYTES))
                begin
                    done.status = ST_TRUNC;
                end
                else if ({1'b0, declared_next} + CNT_W'(LEN_BYTES) != total)
                begin
                    done.status = ST_BADLEN;
                end
                else if (declared_next[3:0] != 4'd0)
                begin
                    done.status = ST_BADLEN;
                end
                else if (count > 12'(MAX_RECORDS))
                begin
                    done.status = ST_UNSUP;
                end
                else
                begin
                    done.status = ST_OK;
                end
                done.has_records = (count != 12'd0);
                done.last_idx    = count[IDX_W-1:0] - 1'b1;

                // drop per-message state
                bytes_seen_next = '0;
                declared_next   = '0;
                acc_next        = '0;
                epoch_next      = '0;
                stored_next     = '0;
            end
        end
    end

endmodule

FILE: hw/rtl/ackp_emit.sv
// Emission sequencer: reads stored records back and issues the status transaction.
// Depends on ackp_pkg.
module ackp_emit
    import ackp_pkg::*;
#(
    parameter int unsigned ADDR_W = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  msg_done_t         done,
    input  logic [127:0]      rd_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    output logic              busy,
    output logic              result_valid,
    output result_t           result
);

    emit_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    logic [1:0]        status_reg, status_next;
    logic              pend_reg, pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        status_next  = status_reg;
        pend_next    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        result_valid = 1'b0;
        result       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (done.valid)
                begin
                    status_next = done.status;
                    idx_next    = '0;
                    last_next   = done.last_idx[ADDR_W-1:0];
                    if (done.status == ST_OK && done.has_records)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_STATUS;
                    end
                end
            end
            S_READ:
            begin
                rd_en     = 1'b1;
                pend_next = 1'b1;
                if (idx_reg == last_reg)
                begin
                    state_next = S_STATUS;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_STATUS:
            begin
                if (!pend_reg)
                begin
                    result_valid        = 1'b1;
                    result.parse_status = status_reg;
                    result.run_end      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (pend_reg)
        begin
            result_valid          = 1'b1;
            result.epoch_value    = rd_data[127:64];
            result.sequence_value = rd_data[63:0];
            result.is_record      = 1'b1;
            result.parse_status   = ST_OK;
            result.run_end        = 1'b0;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: hw/rtl/ack_record_list_parser.sv
// Top level of the acknowledgement record list parser.
// Depends on ackp_pkg, ackp_parse, ackp_store and ackp_emit.
//
// Usage:
//   Input channel: one message byte per transaction on item, taken at a rising
//   edge with start high and busy low. item.final_byte marks the last byte.
//   Bytes are taken one per cycle while busy stays low.
//   Output channel: result holds one transaction for exactly one cycle while
//   result_valid is high. After the final byte of a message the block raises
//   busy, emits the stored records in order (when every check passes) and
//   then one status transaction with run_end set.
//   Emission: with no record to emit, the status transaction comes in the cycle
//   after the final byte; otherwise the records come one per cycle from the
//   store's registered read port, and busy stays high until the status
//   transaction that follows them has been shown.
//   Reset clears all message state and the sequencer; store contents are not
//   cleared and are only read for records of the current message.
//   The receiver cannot stall: each result is taken in the cycle it is shown.
module ack_record_list_parser
    import ackp_pkg::*;
#(
    parameter int unsigned MAX_RECORDS = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  in_item_t item,
    output logic     result_valid,
    output result_t  result
);

    localparam int unsigned ADDR_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

    logic              accept;
    store_wr_t         wr;
    msg_done_t         done;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [127:0]      rd_data;

    assign accept = start && !busy;

    ackp_parse #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .wr     (wr),
        .done   (done)
    );

    ackp_store #(
        .DEPTH  (MAX_RECORDS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ackp_emit #(
        .ADDR_W (ADDR_W)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .done         (done),
        .rd_data      (rd_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    a_final_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.final_byte |=> busy)
        else $error("final byte did not start emission");

    a_mid_byte_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !item.final_byte |=> !result_valid)
        else $error("result after a non-final byte");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside an emission run");

    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.run_end |=> !busy)
        else $error("busy held after status transaction");

endmodule
